### rtl/rayg_pkg.sv
package rayg_pkg;

    localparam int PIXEL_BITS = 12;
    localparam int COMP_W     = 21;
    localparam int VEC_W      = 3 * COMP_W;
    localparam int OFS_W      = 20;
    localparam int INV_W      = 16;
    localparam int DIR_W      = 18;
    localparam int CFG_IDX_W  = 3;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_EYE_POS       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_DIR    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HORIZ_AXIS    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_VERT_AXIS     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_OFFSET = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_INV_WIDTH     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_INV_HEIGHT    = 3'd6;

    // datapath widths
    localparam int PRX_W  = PIXEL_BITS + 1 + INV_W;   // (2x+1)*inv
    localparam int SX_W   = PRX_W + 1;                // signed screen coord, Q.17
    localparam int PR_W   = SX_W + COMP_W;            // axis * coord
    localparam int D_W    = PR_W + 2;                 // direction, Q.29
    localparam int MSB_W  = $clog2(D_W);
    localparam int MAG_W  = 30;                       // normalized magnitude
    localparam int SQ1_W  = 2 * MAG_W;
    localparam int SQ_W   = 64;                       // radicand
    localparam int ROOT_W = 32;
    localparam int REM_W  = 36;
    localparam int NUM_W  = 49;                       // dividend / remainder
    localparam int Q_W    = 18;
    localparam int PW     = DIR_W + OFS_W + 1;        // dir * offset, Q.28
    localparam int SH_W   = PW - 16;
    localparam int OW     = SH_W + 1;

    localparam logic [MSB_W-1:0] NORM_POS = MSB_W'(MAG_W - 1);
    localparam int HALF_Q16  = 65536;
    localparam int ROUND_Q16 = 32768;
    localparam int CENTER_SH = 17;
    localparam int ORG_MAX   = 1048575;
    localparam int ORG_MIN   = -1048576;

    // pipeline stage map
    localparam int ST_SCR      = 0;
    localparam int ST_MUL      = 1;
    localparam int ST_SUM      = 2;
    localparam int ST_ABS      = 3;
    localparam int ST_LOD      = 4;
    localparam int ST_NRM      = 5;
    localparam int ST_SQR      = 6;
    localparam int ST_SSQ      = 7;
    localparam int SQRT_STEPS  = 4;
    localparam int SQRT_STAGES = SQ_W / (2 * SQRT_STEPS);
    localparam int ST_RT0      = ST_SSQ + 1;
    localparam int ST_NUM      = ST_RT0 + SQRT_STAGES;
    localparam int DIV_STEPS   = 3;
    localparam int DIV_STAGES  = Q_W / DIV_STEPS;
    localparam int ST_DV0      = ST_NUM + 1;
    localparam int ST_OFS      = ST_DV0 + DIV_STAGES;
    localparam int ST_ORG      = ST_OFS + 1;
    localparam int NST         = ST_ORG + 1;

    typedef struct packed {
        logic [REM_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
        logic [SQ_W-1:0]   a;
    } sq_t;

    typedef struct packed {
        logic [ROOT_W-1:0]          n;
        logic [2:0][NUM_W-1:0]      r;
        logic [2:0][Q_W-1:0]        q;
    } dv_t;

    typedef struct packed {
        logic [NST-1:0] ld;
        logic [NST-1:0] vld;
    } pipe_ctl_t;

    function automatic logic signed [COMP_W-1:0] comp_of(
        input logic [VEC_W-1:0] v, input int k);
        comp_of = $signed(v[k*COMP_W +: COMP_W]);
    endfunction

    function automatic logic [MSB_W-1:0] msb_idx(input logic [D_W-1:0] v);
        logic [MSB_W-1:0] p;
        p = '0;
        for (int b = 0; b < D_W; b++) begin
            if (v[b]) begin
                p = MSB_W'(b);
            end
        end
        msb_idx = p;
    endfunction

    // one radix-4 digit of the integer square root
    function automatic sq_t sqrt_step(input sq_t s);
        logic [REM_W-1:0]  r2;
        logic [ROOT_W+1:0] t;
        sq_t o;
        r2 = {s.rem[REM_W-3:0], s.a[SQ_W-1 -: 2]};
        t  = {s.root, 2'b01};
        o.a = s.a << 2;
        if (r2 >= REM_W'(t)) begin
            o.rem  = r2 - REM_W'(t);
            o.root = {s.root[ROOT_W-2:0], 1'b1};
        end else begin
            o.rem  = r2;
            o.root = {s.root[ROOT_W-2:0], 1'b0};
        end
        sqrt_step = o;
    endfunction

    // one restoring-division bit for all three components
    function automatic dv_t div_step(input dv_t d, input int bitpos);
        logic [NUM_W-1:0] sub;
        dv_t o;
        o = d;
        sub = NUM_W'(d.n) << bitpos;
        for (int k = 0; k < 3; k++) begin
            if (d.r[k] >= sub) begin
                o.r[k] = d.r[k] - sub;
                o.q[k] = d.q[k] | (Q_W'(1) << bitpos);
            end
        end
        div_step = o;
    endfunction

endpackage

### rtl/rayg_flow.sv
module rayg_flow (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    input  logic                  m_ready,
    output rayg_pkg::pipe_ctl_t   ctl
);

    logic [rayg_pkg::NST-1:0] vld_reg;
    logic [rayg_pkg::NST-1:0] vld_next;
    logic [rayg_pkg::NST-1:0] ld;

    // a stage loads when it is empty or its successor loads
    always_comb begin
        ld[rayg_pkg::NST-1] = !vld_reg[rayg_pkg::NST-1] || m_ready;
        for (int i = rayg_pkg::NST-2; i >= 0; i--) begin
            ld[i] = !vld_reg[i] || ld[i+1];
        end
        vld_next[0] = ld[0] ? s_valid : vld_reg[0];
        for (int i = 1; i < rayg_pkg::NST; i++) begin
            vld_next[i] = ld[i] ? vld_reg[i-1] : vld_reg[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    // ld sits above vld in the packed struct
    assign ctl = {ld, vld_reg};

endmodule

### rtl/pinhole_primary_ray_generator_core.sv
// Channel   Ports                                  Direction
// -------   -------------------------------------  ---------
// pixel     s_valid/s_ready, s_pixel_x/y           in
// ray       m_valid/m_ready, m_dir_*, m_org_*,     out
//           m_degenerate
// config    cfg_wr_en, cfg_index, cfg_wdata        in (write only)
//
// One beat per clock in and out while the ray side is ready; the pipe has NST stages.
// Most of those stages are the 8-stage square-root and 6-stage divider chains.
// Reset (aresetn low, synchronous) empties the pipe and zeroes config.
// A stall on m_ready backs up only full stages; bubbles are squeezed out,
// so the pixel side keeps accepting until every stage holds a beat.
module pinhole_primary_ray_generator_core (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic [rayg_pkg::PIXEL_BITS-1:0]        s_pixel_x,
    input  logic [rayg_pkg::PIXEL_BITS-1:0]        s_pixel_y,
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic signed [rayg_pkg::DIR_W-1:0]      m_dir_x,
    output logic signed [rayg_pkg::DIR_W-1:0]      m_dir_y,
    output logic signed [rayg_pkg::DIR_W-1:0]      m_dir_z,
    output logic signed [rayg_pkg::COMP_W-1:0]     m_org_x,
    output logic signed [rayg_pkg::COMP_W-1:0]     m_org_y,
    output logic signed [rayg_pkg::COMP_W-1:0]     m_org_z,
    output logic                                   m_degenerate,
    input  logic                                   cfg_wr_en,
    input  logic [rayg_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [rayg_pkg::VEC_W-1:0]             cfg_wdata
);

    localparam int NST = rayg_pkg::NST;

    // ---------------- configuration ----------------
    logic [rayg_pkg::VEC_W-1:0] eye_reg, center_reg, horiz_reg, vert_reg;
    logic [rayg_pkg::OFS_W-1:0] ofs_reg;
    logic [rayg_pkg::INV_W-1:0] invw_reg, invh_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            eye_reg    <= '0;
            center_reg <= '0;
            horiz_reg  <= '0;
            vert_reg   <= '0;
            ofs_reg    <= '0;
            invw_reg   <= '0;
            invh_reg   <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                rayg_pkg::REG_EYE_POS:       eye_reg    <= cfg_wdata;
                rayg_pkg::REG_CENTER_DIR:    center_reg <= cfg_wdata;
                rayg_pkg::REG_HORIZ_AXIS:    horiz_reg  <= cfg_wdata;
                rayg_pkg::REG_VERT_AXIS:     vert_reg   <= cfg_wdata;
                rayg_pkg::REG_ORIGIN_OFFSET: ofs_reg    <= cfg_wdata[rayg_pkg::OFS_W-1:0];
                rayg_pkg::REG_INV_WIDTH:     invw_reg   <= cfg_wdata[rayg_pkg::INV_W-1:0];
                rayg_pkg::REG_INV_HEIGHT:    invh_reg   <= cfg_wdata[rayg_pkg::INV_W-1:0];
                default: ;
            endcase
        end
    end

    // ---------------- flow control ----------------
    rayg_pkg::pipe_ctl_t ctl;

    rayg_flow u_flow (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .m_ready (m_ready),
        .ctl     (ctl)
    );

    assign s_ready = ctl.ld[0];
    assign m_valid = ctl.vld[NST-1];

    // ---------------- datapath registers ----------------
    logic [rayg_pkg::PRX_W-1:0]               prx, pry;
    logic signed [rayg_pkg::SX_W-1:0]         sx_reg, sy_reg, sx_next, sy_next;
    logic signed [rayg_pkg::PR_W-1:0]         pv_reg [3];
    logic signed [rayg_pkg::PR_W-1:0]         ph_reg [3];
    logic signed [rayg_pkg::PR_W-1:0]         pv_next [3];
    logic signed [rayg_pkg::PR_W-1:0]         ph_next [3];
    logic signed [rayg_pkg::D_W-1:0]          d_reg [3];
    logic signed [rayg_pkg::D_W-1:0]          d_next [3];
    logic [rayg_pkg::D_W-1:0]                 mag3_reg [3];
    logic [rayg_pkg::D_W-1:0]                 mag3_next [3];
    logic [rayg_pkg::D_W-1:0]                 mag4_reg [3];
    logic [rayg_pkg::D_W-1:0]                 mag4_next [3];
    logic [rayg_pkg::D_W-1:0]                 orv, shv;
    logic [rayg_pkg::MSB_W-1:0]               p_reg, p_next;
    logic [2:0]                               neg_reg [NST];
    logic [2:0]                               neg_next [NST];
    logic                                     zero_reg [NST];
    logic                                     zero_next [NST];
    logic [rayg_pkg::MAG_W-1:0]               magc_reg [NST][3];
    logic [rayg_pkg::MAG_W-1:0]               magc_next [NST][3];
    logic [rayg_pkg::SQ1_W-1:0]               sq_reg [3];
    logic [rayg_pkg::SQ1_W-1:0]               sq_next [3];
    rayg_pkg::sq_t                            sqs_reg [NST];
    rayg_pkg::sq_t                            sqs_next [NST];
    rayg_pkg::dv_t                            dv_reg [NST];
    rayg_pkg::dv_t                            dv_next [NST];
    logic signed [rayg_pkg::DIR_W-1:0]        dir_reg [NST][3];
    logic signed [rayg_pkg::DIR_W-1:0]        dir_next [NST][3];
    logic signed [rayg_pkg::PW-1:0]           prd_reg [3];
    logic signed [rayg_pkg::PW-1:0]           prd_next [3];
    logic signed [rayg_pkg::COMP_W-1:0]       org_reg [3];
    logic signed [rayg_pkg::COMP_W-1:0]       org_next [3];
    logic signed [rayg_pkg::PW-1:0]           rnd;
    logic signed [rayg_pkg::OW-1:0]           osum;
    rayg_pkg::sq_t                            sq_tmp;
    rayg_pkg::dv_t                            dv_tmp;

    always_comb begin
        // default: side fields ride along with the beat
        neg_next[0]  = '0;
        zero_next[0] = 1'b0;
        sqs_next[0]  = '0;
        dv_next[0]   = '0;
        for (int k = 0; k < 3; k++) begin
            magc_next[0][k] = '0;
            dir_next[0][k]  = '0;
        end
        for (int i = 1; i < NST; i++) begin
            neg_next[i]  = neg_reg[i-1];
            zero_next[i] = zero_reg[i-1];
            sqs_next[i]  = sqs_reg[i-1];
            dv_next[i]   = dv_reg[i-1];
            for (int k = 0; k < 3; k++) begin
                magc_next[i][k] = magc_reg[i-1][k];
                dir_next[i][k]  = dir_reg[i-1][k];
            end
        end

        // screen coords, Q.17: (2p+1)*inv - 1/2
        prx = rayg_pkg::PRX_W'({s_pixel_x, 1'b1}) * rayg_pkg::PRX_W'(invw_reg);
        pry = rayg_pkg::PRX_W'({s_pixel_y, 1'b1}) * rayg_pkg::PRX_W'(invh_reg);
        sx_next = $signed({1'b0, prx}) - $signed(rayg_pkg::SX_W'(rayg_pkg::HALF_Q16));
        sy_next = $signed({1'b0, pry}) - $signed(rayg_pkg::SX_W'(rayg_pkg::HALF_Q16));

        // axis products
        for (int k = 0; k < 3; k++) begin
            pv_next[k] = rayg_pkg::PR_W'(rayg_pkg::comp_of(vert_reg, k)) *
                         rayg_pkg::PR_W'(sy_reg);
            ph_next[k] = rayg_pkg::PR_W'(rayg_pkg::comp_of(horiz_reg, k)) *
                         rayg_pkg::PR_W'(sx_reg);
        end

        // direction sum, Q.29
        for (int k = 0; k < 3; k++) begin
            d_next[k] = rayg_pkg::D_W'(pv_reg[k]) + rayg_pkg::D_W'(ph_reg[k]) +
                        (rayg_pkg::D_W'(rayg_pkg::comp_of(center_reg, k))
                         <<< rayg_pkg::CENTER_SH);
        end

        // sign / magnitude
        for (int k = 0; k < 3; k++) begin
            neg_next[rayg_pkg::ST_ABS][k] = d_reg[k][rayg_pkg::D_W-1];
            mag3_next[k] = d_reg[k][rayg_pkg::D_W-1] ? rayg_pkg::D_W'(-d_reg[k])
                                                     : rayg_pkg::D_W'(d_reg[k]);
        end

        // leading one of the largest magnitude = leading one of the OR
        orv = mag3_reg[0] | mag3_reg[1] | mag3_reg[2];
        p_next = rayg_pkg::msb_idx(orv);
        zero_next[rayg_pkg::ST_LOD] = (orv == '0);
        for (int k = 0; k < 3; k++) begin
            mag4_next[k] = mag3_reg[k];
        end

        // common normalize shift: largest lands in [2^29, 2^30)
        for (int k = 0; k < 3; k++) begin
            if (p_reg >= rayg_pkg::NORM_POS) begin
                shv = mag4_reg[k] >> (p_reg - rayg_pkg::NORM_POS);
            end else begin
                shv = mag4_reg[k] << (rayg_pkg::NORM_POS - p_reg);
            end
            magc_next[rayg_pkg::ST_NRM][k] = shv[rayg_pkg::MAG_W-1:0];
        end

        // squares
        for (int k = 0; k < 3; k++) begin
            sq_next[k] = rayg_pkg::SQ1_W'(magc_reg[rayg_pkg::ST_NRM][k]) *
                         rayg_pkg::SQ1_W'(magc_reg[rayg_pkg::ST_NRM][k]);
        end

        // sum of squares seeds the root recurrence
        sqs_next[rayg_pkg::ST_SSQ].rem  = '0;
        sqs_next[rayg_pkg::ST_SSQ].root = '0;
        sqs_next[rayg_pkg::ST_SSQ].a    = rayg_pkg::SQ_W'(sq_reg[0]) +
                                          rayg_pkg::SQ_W'(sq_reg[1]) +
                                          rayg_pkg::SQ_W'(sq_reg[2]);

        // integer square root, four digits per stage
        for (int j = 0; j < rayg_pkg::SQRT_STAGES; j++) begin
            sq_tmp = sqs_reg[rayg_pkg::ST_RT0 + j - 1];
            for (int s = 0; s < rayg_pkg::SQRT_STEPS; s++) begin
                sq_tmp = rayg_pkg::sqrt_step(sq_tmp);
            end
            sqs_next[rayg_pkg::ST_RT0 + j] = sq_tmp;
        end

        // dividend: mag*2^16 + n/2
        dv_next[rayg_pkg::ST_NUM].n = sqs_reg[rayg_pkg::ST_NUM-1].root;
        for (int k = 0; k < 3; k++) begin
            dv_next[rayg_pkg::ST_NUM].r[k] =
                (rayg_pkg::NUM_W'(magc_reg[rayg_pkg::ST_NUM-1][k]) << 16) +
                rayg_pkg::NUM_W'(sqs_reg[rayg_pkg::ST_NUM-1].root >> 1);
            dv_next[rayg_pkg::ST_NUM].q[k] = '0;
        end

        // restoring divide, three quotient bits per stage
        for (int j = 0; j < rayg_pkg::DIV_STAGES; j++) begin
            dv_tmp = dv_reg[rayg_pkg::ST_DV0 + j - 1];
            for (int s = 0; s < rayg_pkg::DIV_STEPS; s++) begin
                dv_tmp = rayg_pkg::div_step(dv_tmp,
                    rayg_pkg::Q_W - 1 - rayg_pkg::DIV_STEPS * j - s);
            end
            dv_next[rayg_pkg::ST_DV0 + j] = dv_tmp;
        end

        // signed unit direction and origin offset product
        for (int k = 0; k < 3; k++) begin
            if (zero_reg[rayg_pkg::ST_OFS-1]) begin
                dir_next[rayg_pkg::ST_OFS][k] = '0;
            end else if (neg_reg[rayg_pkg::ST_OFS-1][k]) begin
                dir_next[rayg_pkg::ST_OFS][k] =
                    -$signed(dv_reg[rayg_pkg::ST_OFS-1].q[k]);
            end else begin
                dir_next[rayg_pkg::ST_OFS][k] =
                    $signed(dv_reg[rayg_pkg::ST_OFS-1].q[k]);
            end
            prd_next[k] = rayg_pkg::PW'(dir_next[rayg_pkg::ST_OFS][k]) *
                          rayg_pkg::PW'($signed({1'b0, ofs_reg}));
        end

        // round half up to Q.12, add eye, saturate
        for (int k = 0; k < 3; k++) begin
            rnd  = (prd_reg[k] + rayg_pkg::PW'(rayg_pkg::ROUND_Q16)) >>> 16;
            osum = rayg_pkg::OW'(rayg_pkg::comp_of(eye_reg, k)) +
                   rayg_pkg::OW'($signed(rnd[rayg_pkg::SH_W-1:0]));
            if (osum > rayg_pkg::OW'(rayg_pkg::ORG_MAX)) begin
                org_next[k] = rayg_pkg::COMP_W'(rayg_pkg::ORG_MAX);
            end else if (osum < rayg_pkg::OW'(rayg_pkg::ORG_MIN)) begin
                org_next[k] = rayg_pkg::COMP_W'(rayg_pkg::ORG_MIN);
            end else begin
                org_next[k] = osum[rayg_pkg::COMP_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.ld[rayg_pkg::ST_SCR]) begin
            sx_reg <= sx_next;
            sy_reg <= sy_next;
        end
        if (ctl.ld[rayg_pkg::ST_MUL]) begin
            pv_reg <= pv_next;
            ph_reg <= ph_next;
        end
        if (ctl.ld[rayg_pkg::ST_SUM]) begin
            d_reg <= d_next;
        end
        if (ctl.ld[rayg_pkg::ST_ABS]) begin
            mag3_reg <= mag3_next;
        end
        if (ctl.ld[rayg_pkg::ST_LOD]) begin
            mag4_reg <= mag4_next;
            p_reg    <= p_next;
        end
        if (ctl.ld[rayg_pkg::ST_SQR]) begin
            sq_reg <= sq_next;
        end
        if (ctl.ld[rayg_pkg::ST_OFS]) begin
            prd_reg <= prd_next;
        end
        if (ctl.ld[rayg_pkg::ST_ORG]) begin
            org_reg <= org_next;
        end
        for (int i = 0; i < NST; i++) begin
            if (ctl.ld[i]) begin
                neg_reg[i]  <= neg_next[i];
                zero_reg[i] <= zero_next[i];
                magc_reg[i] <= magc_next[i];
                sqs_reg[i]  <= sqs_next[i];
                dv_reg[i]   <= dv_next[i];
                dir_reg[i]  <= dir_next[i];
            end
        end
    end

    assign m_dir_x      = dir_reg[NST-1][0];
    assign m_dir_y      = dir_reg[NST-1][1];
    assign m_dir_z      = dir_reg[NST-1][2];
    assign m_org_x      = org_reg[0];
    assign m_org_y      = org_reg[1];
    assign m_org_z      = org_reg[2];
    assign m_degenerate = zero_reg[NST-1];

endmodule

### rtl/rayg_checker.sv
module rayg_checker (
    input logic                                aclk,
    input logic                                aresetn,
    input logic                                s_ready,
    input logic                                m_valid,
    input logic                                m_ready,
    input logic signed [rayg_pkg::DIR_W-1:0]   m_dir_x,
    input logic signed [rayg_pkg::DIR_W-1:0]   m_dir_y,
    input logic signed [rayg_pkg::DIR_W-1:0]   m_dir_z,
    input logic                                m_degenerate
);

    // held ray beat keeps its direction
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_dir_x) && $stable(m_dir_y)
                                && $stable(m_dir_z))
        else $error("ray beat changed while stalled");

    a_degen: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_degenerate |-> m_dir_x == '0 && m_dir_y == '0 && m_dir_z == '0)
        else $error("degenerate ray with nonzero direction");

    a_unit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_dir_x <= 18'sd65536 && m_dir_x >= -18'sd65536 &&
                    m_dir_y <= 18'sd65536 && m_dir_y >= -18'sd65536 &&
                    m_dir_z <= 18'sd65536 && m_dir_z >= -18'sd65536)
        else $error("direction component out of unit range");

    a_empty_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled while output empty");

    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("ray valid after reset");

endmodule

bind pinhole_primary_ray_generator_core rayg_checker u_rayg_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .s_ready      (s_ready),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_dir_x      (m_dir_x),
    .m_dir_y      (m_dir_y),
    .m_dir_z      (m_dir_z),
    .m_degenerate (m_degenerate)
);

### test/ray_checker.sv
module ray_checker (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    input  logic                                s_ready,
    input  logic [rayg_pkg::PIXEL_BITS-1:0]     s_pixel_x,
    input  logic [rayg_pkg::PIXEL_BITS-1:0]     s_pixel_y,
    input  logic                                m_valid,
    input  logic                                m_ready,
    input  logic signed [rayg_pkg::DIR_W-1:0]   m_dir_x,
    input  logic signed [rayg_pkg::DIR_W-1:0]   m_dir_y,
    input  logic signed [rayg_pkg::DIR_W-1:0]   m_dir_z,
    input  logic signed [rayg_pkg::COMP_W-1:0]  m_org_x,
    input  logic signed [rayg_pkg::COMP_W-1:0]  m_org_y,
    input  logic signed [rayg_pkg::COMP_W-1:0]  m_org_z,
    input  logic                                m_degenerate,
    input  logic                                cfg_wr_en,
    input  logic [rayg_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [rayg_pkg::VEC_W-1:0]          cfg_wdata,
    output int                                  err_count,
    output int                                  rays_pending
);
    import rayg_pkg::*;

    typedef struct {
        logic signed [DIR_W-1:0]  dir [3];
        logic signed [COMP_W-1:0] org [3];
        logic                     degen;
    } ray_t;

    logic [VEC_W-1:0] eye, center, horiz, vert;
    logic [OFS_W-1:0] ofs;
    logic [INV_W-1:0] inv_w, inv_h;
    ray_t rays_q[$];

    assign rays_pending = rays_q.size();

    function automatic longint sext(input logic [VEC_W-1:0] v, input int k);
        logic signed [COMP_W-1:0] c;
        c = v[k*COMP_W +: COMP_W];
        return longint'(c);
    endfunction

    function automatic longint unsigned root64(input longint unsigned a);
        longint unsigned r, rem;
        r = 0;
        rem = 0;
        for (int i = 0; i < 32; i++) begin
            rem = (rem << 2) | ((a >> 62) & 3);
            a = a << 2;
            r = r << 1;
            if (rem >= (r << 1) + 1) begin
                rem = rem - ((r << 1) + 1);
                r = r + 1;
            end
        end
        return r;
    endfunction

    function automatic longint q28_to_q12(input longint p);
        longint t;
        t = p + 32768;
        if (t >= 0) return t >>> 16;
        return -((-t + 65535) >>> 16);
    endfunction

    function automatic ray_t trace_ray(input logic [PIXEL_BITS-1:0] px,
                                       input logic [PIXEL_BITS-1:0] py);
        ray_t r;
        longint sx, sy, d, o;
        longint dirv [3];
        longint unsigned mag [3];
        longint unsigned m, sum, n, q;
        bit neg [3];
        int rs, ls;
        sx = longint'((2 * longint'(px) + 1) * longint'(inv_w)) - 65536;
        sy = longint'((2 * longint'(py) + 1) * longint'(inv_h)) - 65536;
        m = 0;
        for (int k = 0; k < 3; k++) begin
            d = sext(vert, k) * sy + sext(horiz, k) * sx + sext(center, k) * 131072;
            neg[k] = d < 0;
            mag[k] = neg[k] ? -d : d;
            if (mag[k] > m) m = mag[k];
        end
        r.degen = (m == 0);
        if (m == 0) begin
            for (int k = 0; k < 3; k++) dirv[k] = 0;
        end else begin
            rs = 0;
            ls = 0;
            sum = 0;
            while ((m >> rs) >= (64'd1 << 30)) rs++;
            while ((m << ls) < (64'd1 << 29)) ls++;
            for (int k = 0; k < 3; k++) begin
                mag[k] = (mag[k] >> rs) << ls;
                sum += mag[k] * mag[k];
            end
            n = root64(sum);
            for (int k = 0; k < 3; k++) begin
                q = (mag[k] * 65536 + (n >> 1)) / n;
                dirv[k] = neg[k] ? -longint'(q) : longint'(q);
            end
        end
        for (int k = 0; k < 3; k++) begin
            o = sext(eye, k) + q28_to_q12(dirv[k] * longint'(ofs));
            if (o > ORG_MAX) o = ORG_MAX;
            if (o < ORG_MIN) o = ORG_MIN;
            r.dir[k] = dirv[k][DIR_W-1:0];
            r.org[k] = o[COMP_W-1:0];
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what, input longint got,
                                   input longint want);
        $display("ERROR %0t: %s got %0d expected %0d", $time, what, got, want);
        err_count++;
    endtask

    always @(posedge aclk) begin
        ray_t w;
        if (!aresetn) begin
            eye <= '0; center <= '0; horiz <= '0; vert <= '0;
            ofs <= '0; inv_w <= '0; inv_h <= '0;
            rays_q.delete();
            err_count = 0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_EYE_POS:       eye    <= cfg_wdata;
                    REG_CENTER_DIR:    center <= cfg_wdata;
                    REG_HORIZ_AXIS:    horiz  <= cfg_wdata;
                    REG_VERT_AXIS:     vert   <= cfg_wdata;
                    REG_ORIGIN_OFFSET: ofs    <= cfg_wdata[OFS_W-1:0];
                    REG_INV_WIDTH:     inv_w  <= cfg_wdata[INV_W-1:0];
                    REG_INV_HEIGHT:    inv_h  <= cfg_wdata[INV_W-1:0];
                    default: ;
                endcase
            end
            if (m_valid && m_ready) begin
                if (rays_q.size() == 0) begin
                    report_mismatch("unexpected ray beat", 1, 0);
                end else begin
                    w = rays_q.pop_front();
                    if (m_dir_x != w.dir[0]) report_mismatch("dir_x", m_dir_x, w.dir[0]);
                    if (m_dir_y != w.dir[1]) report_mismatch("dir_y", m_dir_y, w.dir[1]);
                    if (m_dir_z != w.dir[2]) report_mismatch("dir_z", m_dir_z, w.dir[2]);
                    if (m_org_x != w.org[0]) report_mismatch("org_x", m_org_x, w.org[0]);
                    if (m_org_y != w.org[1]) report_mismatch("org_y", m_org_y, w.org[1]);
                    if (m_org_z != w.org[2]) report_mismatch("org_z", m_org_z, w.org[2]);
                    if (m_degenerate != w.degen)
                        report_mismatch("degenerate", m_degenerate, w.degen);
                end
            end
            if (s_valid && s_ready) rays_q.push_back(trace_ray(s_pixel_x, s_pixel_y));
        end
    end
endmodule

### test/pinhole_primary_ray_generator_core_tb.sv
module pinhole_primary_ray_generator_core_tb;
    import rayg_pkg::*;

    localparam int STALL_LIMIT = 2000;  // far above the pipe latency plus the longest ready stall
    localparam int NUM_RANDOM  = 1500;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0, s_ready;
    logic [PIXEL_BITS-1:0] s_pixel_x = '0, s_pixel_y = '0;
    logic m_valid, m_ready = 1'b0;
    logic signed [DIR_W-1:0] m_dir_x, m_dir_y, m_dir_z;
    logic signed [COMP_W-1:0] m_org_x, m_org_y, m_org_z;
    logic m_degenerate;
    logic cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [VEC_W-1:0] cfg_wdata = '0;
    int err_count, rays_pending;
    int idle_cycles = 0;
    bit calm = 0;       // no idling during the tail of the run

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    pinhole_primary_ray_generator_core i_dut (.*);

    ray_checker i_checker (.*);

    // Watchdog: count cycles with no beat on either channel.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn)
            idle_cycles <= 0;
        else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("pinhole_primary_ray_generator_core_tb failed");
                $finish;
            end
        end
    end

    // Receiver: ready drops in random bursts, none in the tail.
    initial begin
        int n;
        forever begin
            @(negedge aclk);
            if (!calm && $urandom_range(0, 7) == 0) begin
                m_ready <= 1'b0;
                n = $urandom_range(1, 9);
                repeat (n) @(negedge aclk);
            end
            m_ready <= 1'b1;
        end
    end

    // Write enable stays high across back-to-back writes; the caller drops it.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [VEC_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
    endtask

    // Random packed vector; each component small, zero, fully random or at an extreme.
    function automatic logic [VEC_W-1:0] rand_vec();
        logic [VEC_W-1:0] v;
        logic [COMP_W-1:0] c;
        for (int k = 0; k < 3; k++) begin
            case ($urandom_range(0, 4))
                0: c = COMP_W'($urandom_range(0, 8191)) - COMP_W'(4096);
                1: c = {1'b0, {(COMP_W-1){1'b1}}};
                2: c = {1'b1, {(COMP_W-1){1'b0}}};
                3: c = '0;
                default: c = COMP_W'($urandom);
            endcase
            v[k*COMP_W +: COMP_W] = c;
        end
        return v;
    endfunction

    // Send one pixel beat, with an optional idle burst before it.
    task automatic send_pixel(input logic [PIXEL_BITS-1:0] px, input logic [PIXEL_BITS-1:0] py);
        int n;
        if (!calm && $urandom_range(0, 5) == 0) begin
            s_valid <= 1'b0;
            n = $urandom_range(1, 9);
            repeat (n) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_pixel_x <= px;
        s_pixel_y <= py;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
    endtask

    // Quiesce: stop sending, wait for every ray, then let the pipe drain.
    task automatic drain();
        s_valid <= 1'b0;
        while (rays_pending != 0) @(negedge aclk);
        repeat (30) @(negedge aclk);
    endtask

    task automatic set_camera(input logic [VEC_W-1:0] e, input logic [VEC_W-1:0] c,
                              input logic [VEC_W-1:0] h, input logic [VEC_W-1:0] v,
                              input logic [VEC_W-1:0] o, input logic [VEC_W-1:0] iw,
                              input logic [VEC_W-1:0] ih);
        write_reg(REG_EYE_POS, e);
        write_reg(REG_CENTER_DIR, c);
        write_reg(REG_HORIZ_AXIS, h);
        write_reg(REG_VERT_AXIS, v);
        write_reg(REG_ORIGIN_OFFSET, o);
        write_reg(REG_INV_WIDTH, iw);
        write_reg(REG_INV_HEIGHT, ih);
        cfg_wr_en <= 1'b0;
    endtask

    initial begin
        logic [VEC_W-1:0] ones;
        int px, py;
        ones = '1;
        repeat (3) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // All-zero registers: every ray is degenerate.
        send_pixel('0, '0);
        send_pixel('1, '1);
        drain();

        // Typical camera, 64x64 raster, forward along +z (1.0 in Q9.12).
        set_camera('0, VEC_W'(64'd4096 << 42), VEC_W'(64'd4096),
                   VEC_W'(64'd4096 << 21), VEC_W'(20'd4096), VEC_W'(16'd1024),
                   VEC_W'(16'd1024));
        send_pixel('0, '0);
        send_pixel(PIXEL_BITS'(63), PIXEL_BITS'(63));
        send_pixel(PIXEL_BITS'(32), PIXEL_BITS'(32));   // center pixel lands near axis
        send_pixel('1, '0);
        send_pixel('0, '1);
        send_pixel(12'hAAA, 12'h555);
        send_pixel(12'h555, 12'hAAA);
        drain();

        // Exact zero direction from a nonzero pixel: inv=32768, x=0 gives sx=-32768,
        // center cancels horiz*sx when center = horiz/4.
        set_camera(VEC_W'(64'd5), VEC_W'(64'd1024), VEC_W'(64'd4096), '0,
                   VEC_W'(20'd8192), VEC_W'(16'd32768), VEC_W'(16'd0));
        send_pixel('0, PIXEL_BITS'(7));
        drain();

        // Extremes: saturating eye and offset, full-scale axes, max reciprocals.
        set_camera(ones, ones >> 1, ones, {1'b1, {(VEC_W-1){1'b0}}},
                   ones, ones, ones);
        send_pixel('0, '0);
        send_pixel('1, '1);
        send_pixel(PIXEL_BITS'(1), PIXEL_BITS'(4094));
        drain();
        set_camera({3{1'b0, {(COMP_W-1){1'b1}}}}, {3{1'b1, {(COMP_W-1){1'b0}}}},
                   {3{1'b0, {(COMP_W-1){1'b1}}}}, '0, VEC_W'(20'hFFFFF),
                   VEC_W'(16'd1), VEC_W'(16'd65535));
        send_pixel('0, '1);
        send_pixel('1, '0);
        drain();
        // Out-of-list register index is ignored.
        write_reg(CFG_IDX_W'(7), ones);
        cfg_wr_en <= 1'b0;
        send_pixel(PIXEL_BITS'(5), PIXEL_BITS'(5));
        drain();

        // Random phases with a new camera each time.
        for (int ph = 0; ph < 6; ph++) begin
            set_camera(rand_vec(), rand_vec(), rand_vec(), rand_vec(),
                       VEC_W'($urandom), VEC_W'($urandom), VEC_W'($urandom));
            for (int i = 0; i < NUM_RANDOM / 6; i++) begin
                if (ph == 5 && i > NUM_RANDOM / 12) calm = 1;
                px = $urandom;
                py = $urandom;
                send_pixel(PIXEL_BITS'(px), PIXEL_BITS'(py));
            end
            drain();
        end

        if (err_count == 0)
            $display("pinhole_primary_ray_generator_core_tb passed");
        else
            $display("pinhole_primary_ray_generator_core_tb failed");
        $finish;
    end
endmodule
